// File: sv/pefc_pkg.sv
// Shared types, constants and codes of the position error fingerprint corrector.
`timescale 1ns / 1ps

package pefc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int CELL_MM     = 100;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 24;
  localparam int KEY_W       = 18;
  localparam int ERR_W       = 25;
  localparam int OUT_W       = 25;
  localparam int ENTRY_W     = 2 * KEY_W + 2 * ERR_W;

  // Reciprocal of the cell size, rounded down, in Q30.
  localparam int        RECIP_SH = 30;
  localparam longint    RECIP_M  = (64'd1 << RECIP_SH) / CELL_MM;

  localparam int EXP_TERMS  = 13;
  localparam int SQR_ROUNDS = 4;
  localparam int DIVT_STEPS = 20;
  localparam int DIVK_STEPS = 31;

  localparam logic [1:0] FUNC_REF   = 2'd0;
  localparam logic [1:0] FUNC_MEAS  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] GROUND_NONE = 2'd3;

  localparam logic [3:0] REG_GROUND = 4'd0;
  localparam logic [3:0] REG_TOL    = 4'd1;
  localparam logic [3:0] REG_SCALE  = 4'd2;
  localparam logic [3:0] REG_FP_EN  = 4'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_KEYM,
    OP_KEYF,
    OP_SQX,
    OP_SQY,
    OP_DIVT_LD,
    OP_DIV_STEP,
    OP_EXP_INIT,
    OP_TMUL,
    OP_TACC,
    OP_CLAMP,
    OP_SQR,
    OP_EFIN,
    OP_ERRX,
    OP_ERRY,
    OP_SRCH_INIT,
    OP_SRCH,
    OP_INSERT,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic       load;
    dp_op_e     op;
    logic [3:0] k;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       s_big;
    logic       div_done;
    logic       srch_done;
    logic       on_grid;
  } status_t;

  typedef struct packed {
    logic [1:0]  ground;
    logic [23:0] tol;
    logic [31:0] scale;
    logic        fp_en;
  } cfg_t;

endpackage

// File: sv/pefc_ctrl.sv
// Sequencer of the corrector: steps the datapath through one request at a time.
`timescale 1ns / 1ps

module pefc_ctrl
  import pefc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_KEYM, S_KEYF, S_SQX, S_SQY, S_SCHK, S_DIVT_LD, S_DIVT,
    S_EXP_INIT, S_TMUL, S_TDIV, S_TACC, S_CLAMP, S_SQR, S_EFIN, S_ERRX, S_ERRY,
    S_SRCH_INIT, S_SRCH, S_INSERT, S_OUTW
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] k_q, k_d;
  logic [1:0] sqc_q, sqc_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    sqc_d       = sqc_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.load  = accept;
    cmd_o.op    = OP_NONE;
    cmd_o.k     = k_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_DISP;
      S_DISP: begin
        if (sts_i.func == FUNC_MEAS || sts_i.func == FUNC_QUERY) state_d = S_KEYM;
        else state_d = S_IDLE;
      end
      S_KEYM: begin
        cmd_o.op = OP_KEYM;
        state_d  = S_KEYF;
      end
      S_KEYF: begin
        cmd_o.op = OP_KEYF;
        if (sts_i.func == FUNC_MEAS) state_d = S_SQX;
        else state_d = S_SCHK;
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        // query: grid check; measurement: range check of the exponent
        if (sts_i.func == FUNC_QUERY) begin
          state_d = sts_i.on_grid ? S_SRCH_INIT : S_OUTW;
        end else begin
          state_d = sts_i.s_big ? S_EFIN : S_DIVT_LD;
        end
      end
      S_DIVT_LD: begin
        cmd_o.op = OP_DIVT_LD;
        state_d  = S_DIVT;
      end
      S_DIVT: begin
        if (sts_i.div_done) state_d = S_EXP_INIT;
        else cmd_o.op = OP_DIV_STEP;
      end
      S_EXP_INIT: begin
        cmd_o.op = OP_EXP_INIT;
        k_d      = 4'd1;
        state_d  = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.op = OP_TMUL;
        state_d  = S_TDIV;
      end
      S_TDIV: begin
        if (sts_i.div_done) state_d = S_TACC;
        else cmd_o.op = OP_DIV_STEP;
      end
      S_TACC: begin
        cmd_o.op = OP_TACC;
        if (k_q == 4'(EXP_TERMS)) begin
          state_d = S_CLAMP;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_TMUL;
        end
      end
      S_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        sqc_d    = '0;
        state_d  = S_SQR;
      end
      S_SQR: begin
        cmd_o.op = OP_SQR;
        sqc_d    = sqc_q + 2'd1;
        if (sqc_q == 2'(SQR_ROUNDS - 1)) state_d = S_EFIN;
      end
      S_EFIN: begin
        cmd_o.op = OP_EFIN;
        state_d  = S_ERRX;
      end
      S_ERRX: begin
        cmd_o.op = OP_ERRX;
        state_d  = S_ERRY;
      end
      S_ERRY: begin
        cmd_o.op = OP_ERRY;
        state_d  = S_SRCH_INIT;
      end
      S_SRCH_INIT: begin
        cmd_o.op = OP_SRCH_INIT;
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.op = OP_SRCH;
        if (sts_i.srch_done) begin
          state_d = (sts_i.func == FUNC_MEAS) ? S_INSERT : S_OUTW;
        end
      end
      S_INSERT: begin
        cmd_o.op = OP_INSERT;
        state_d  = S_OUTW;
      end
      S_OUTW: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 4'd1;
      sqc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      sqc_q       <= sqc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/pefc_dp.sv
// Datapath of the corrector: references, key, exponent, divider, table and result.
`timescale 1ns / 1ps

module pefc_dp
  import pefc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  cfg_t                    cfg_i,
  output status_t                 sts_o,
  input  logic [1:0]              in_func_i,
  input  logic [1:0]              in_source_i,
  input  logic signed [POS_W-1:0] in_pos_x_i,
  input  logic signed [POS_W-1:0] in_pos_y_i,
  input  logic signed [POS_W-1:0] in_pos_z_i,
  output logic signed [OUT_W-1:0] out_corrected_x_o,
  output logic signed [OUT_W-1:0] out_corrected_y_o,
  output logic signed [POS_W-1:0] out_corrected_z_o,
  output logic signed [ERR_W-1:0] out_applied_err_x_o,
  output logic signed [ERR_W-1:0] out_applied_err_y_o,
  output logic                    out_key_found_o
);

  localparam logic [30:0] Q30_ONE = 31'(64'd1 << 30);

  logic signed [POS_W-1:0] ref_x_q [3];
  logic signed [POS_W-1:0] ref_y_q [3];
  logic [1:0]              func_q;
  logic signed [POS_W-1:0] px_q, py_q, pz_q;
  logic signed [POS_W:0]   dx_q, dy_q;
  logic [POS_W-1:0]        qx_q, qy_q;
  logic signed [KEY_W-1:0] cx_q, cy_q;
  logic                    on_grid_q;
  logic [47:0]             sq_q;
  logic [48:0]             s_q;
  logic [31:0]             rem_q, dvs_q;
  logic [30:0]             num_q, quo_q;
  logic [4:0]              dcnt_q;
  logic [29:0]             u_q;
  logic [30:0]             term_q, y_q;
  logic signed [32:0]      sum_q;
  logic [16:0]             e_q;
  logic signed [ERR_W-1:0] ex_q, ey_q;
  logic [CNT_W-1:0]        fill_q, sidx_q;
  logic                    pend_q, hit_q;
  logic signed [ERR_W-1:0] hit_ex_q, hit_ey_q;
  logic [ENTRY_W-1:0]      mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]      rd_q;
  logic signed [OUT_W-1:0] cor_x_q, cor_y_q;
  logic signed [POS_W-1:0] cor_z_q;
  logic signed [ERR_W-1:0] app_x_q, app_y_q;
  logic                    found_q;

  // reference selection and input magnitudes
  logic signed [POS_W-1:0] gx, gy;
  logic [POS_W-1:0]        absx, absy, absdx, absdy, absd_sel;
  logic [POS_W-1:0]        rx, ry, qx_fix, qy_fix, rx_fix, ry_fix;
  logic [63:0]             mx, my;
  logic [31:0]             scale_eff;
  logic [32:0]             r2;
  logic                    ge;
  logic [60:0]             tprod;
  logic [61:0]             ysq;
  logic [47:0]             dsq;
  logic [40:0]             eprod;
  logic [ERR_W-1:0]        mag;
  logic signed [ERR_W-1:0] err_val;
  logic                    d_neg;
  logic                    rd_en, match, ins_ok;
  logic signed [ERR_W-1:0] sel_ex, sel_ey;
  logic signed [OUT_W:0]   sum_x, sum_y;
  logic signed [OUT_W-1:0] sat_x, sat_y;

  always_comb begin
    gx = '0;
    gy = '0;
    if (cfg_i.ground != GROUND_NONE) begin
      gx = ref_x_q[cfg_i.ground];
      gy = ref_y_q[cfg_i.ground];
    end
  end

  assign absx  = px_q[POS_W-1] ? POS_W'(-px_q) : POS_W'(px_q);
  assign absy  = py_q[POS_W-1] ? POS_W'(-py_q) : POS_W'(py_q);
  assign absdx = dx_q[POS_W] ? POS_W'(-dx_q) : POS_W'(dx_q);
  assign absdy = dy_q[POS_W] ? POS_W'(-dy_q) : POS_W'(dy_q);

  assign mx = 64'(absx) * 64'(RECIP_M);
  assign my = 64'(absy) * 64'(RECIP_M);

  // one compare-and-subtract fixes the low reciprocal estimate
  assign rx     = absx - POS_W'(qx_q * CELL_MM);
  assign ry     = absy - POS_W'(qy_q * CELL_MM);
  assign qx_fix = (rx >= POS_W'(CELL_MM)) ? qx_q + 1'b1 : qx_q;
  assign qy_fix = (ry >= POS_W'(CELL_MM)) ? qy_q + 1'b1 : qy_q;
  assign rx_fix = (rx >= POS_W'(CELL_MM)) ? rx - POS_W'(CELL_MM) : rx;
  assign ry_fix = (ry >= POS_W'(CELL_MM)) ? ry - POS_W'(CELL_MM) : ry;

  assign dsq = (cmd_i.op == OP_SQY) ? 48'(absdy) * 48'(absdy)
                                    : 48'(absdx) * 48'(absdx);

  assign scale_eff = (cfg_i.scale == '0) ? 32'd1 : cfg_i.scale;

  // restoring divider, one quotient bit a cycle
  assign r2 = {rem_q, num_q[30]};
  assign ge = (r2 >= {1'b0, dvs_q});

  assign tprod = 61'(term_q) * 61'(u_q);
  assign ysq   = 62'(y_q) * 62'(y_q) + 62'(64'd1 << 29);

  // per-axis error, shared by both axes
  assign absd_sel = (cmd_i.op == OP_ERRY) ? absdy : absdx;
  assign d_neg    = (cmd_i.op == OP_ERRY) ? dy_q[POS_W] : dx_q[POS_W];
  assign eprod    = 41'(absd_sel) * 41'(e_q) + 41'd32768;
  assign mag      = ERR_W'(eprod >> 16);
  always_comb begin
    if (absd_sel <= cfg_i.tol) err_val = '0;
    else if (d_neg) err_val = -$signed(mag);
    else err_val = $signed(mag);
  end

  // table search
  assign rd_en = (cmd_i.op == OP_SRCH) && (sidx_q < fill_q);
  assign match = pend_q
              && ($signed(rd_q[ENTRY_W-1 -: KEY_W]) == cx_q)
              && ($signed(rd_q[ENTRY_W-KEY_W-1 -: KEY_W]) == cy_q);
  assign ins_ok = cfg_i.fp_en && ((ex_q != '0) || (ey_q != '0)) && !hit_q
               && (fill_q < CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_INSERT && ins_ok) begin
      mem[fill_q[ADDR_W-1:0]] <= {cx_q, cy_q, ex_q, ey_q};
    end
    if (rd_en) rd_q <= mem[sidx_q[ADDR_W-1:0]];
  end

  // result forming
  assign sel_ex = hit_q ? hit_ex_q : '0;
  assign sel_ey = hit_q ? hit_ey_q : '0;
  assign sum_x  = (OUT_W+1)'(px_q) + (OUT_W+1)'(sel_ex);
  assign sum_y  = (OUT_W+1)'(py_q) + (OUT_W+1)'(sel_ey);
  assign sat_x  = (sum_x[OUT_W] != sum_x[OUT_W-1])
                ? {sum_x[OUT_W], {(OUT_W-1){~sum_x[OUT_W]}}} : OUT_W'(sum_x);
  assign sat_y  = (sum_y[OUT_W] != sum_y[OUT_W-1])
                ? {sum_y[OUT_W], {(OUT_W-1){~sum_y[OUT_W]}}} : OUT_W'(sum_y);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ref_x_q[i] <= '0;
        ref_y_q[i] <= '0;
      end
      func_q <= FUNC_REF;
      fill_q <= '0;
      sidx_q <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        func_q <= in_func_i;
        hit_q  <= 1'b0;
        if (in_func_i == FUNC_REF && in_source_i != 2'd3) begin
          ref_x_q[in_source_i] <= in_pos_x_i;
          ref_y_q[in_source_i] <= in_pos_y_i;
        end
      end
      case (cmd_i.op)
        OP_DIVT_LD: dcnt_q <= 5'(DIVT_STEPS);
        OP_TMUL:    dcnt_q <= 5'(DIVK_STEPS);
        OP_DIV_STEP: if (dcnt_q != '0) dcnt_q <= dcnt_q - 5'd1;
        OP_SRCH_INIT: begin
          sidx_q <= '0;
          pend_q <= 1'b0;
          hit_q  <= 1'b0;
        end
        OP_SRCH: begin
          if (rd_en) sidx_q <= sidx_q + 1'b1;
          pend_q <= rd_en;
          if (match) hit_q <= 1'b1;
        end
        OP_INSERT: begin
          if (ins_ok) begin
            fill_q <= fill_q + 1'b1;
            hit_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= in_pos_x_i;
      py_q <= in_pos_y_i;
      pz_q <= in_pos_z_i;
      dx_q <= (POS_W+1)'(gx) - (POS_W+1)'(in_pos_x_i);
      dy_q <= (POS_W+1)'(gy) - (POS_W+1)'(in_pos_y_i);
    end
    case (cmd_i.op)
      OP_KEYM: begin
        qx_q <= POS_W'(mx >> RECIP_SH);
        qy_q <= POS_W'(my >> RECIP_SH);
      end
      OP_KEYF: begin
        cx_q      <= px_q[POS_W-1] ? -$signed(KEY_W'(qx_fix)) : $signed(KEY_W'(qx_fix));
        cy_q      <= py_q[POS_W-1] ? -$signed(KEY_W'(qy_fix)) : $signed(KEY_W'(qy_fix));
        on_grid_q <= (rx_fix == '0) && (ry_fix == '0);
      end
      OP_SQX: sq_q <= dsq;
      OP_SQY: s_q  <= 49'(sq_q) + 49'(dsq);
      OP_DIVT_LD: begin
        rem_q <= 32'(s_q >> 4);
        num_q <= {s_q[3:0], 27'd0};
        dvs_q <= scale_eff;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if (dcnt_q != '0) begin
          rem_q <= ge ? 32'(r2 - {1'b0, dvs_q}) : r2[31:0];
          quo_q <= {quo_q[29:0], ge};
          num_q <= {num_q[29:0], 1'b0};
        end
      end
      OP_EXP_INIT: begin
        u_q    <= {quo_q[19:0], 10'd0};
        term_q <= Q30_ONE;
        sum_q  <= $signed({2'b00, Q30_ONE});
      end
      OP_TMUL: begin
        num_q <= 31'(tprod >> 30);
        rem_q <= '0;
        dvs_q <= 32'(cmd_i.k);
        quo_q <= '0;
      end
      OP_TACC: begin
        term_q <= quo_q;
        if (cmd_i.k[0]) sum_q <= sum_q - $signed({2'b00, quo_q});
        else sum_q <= sum_q + $signed({2'b00, quo_q});
      end
      OP_CLAMP: begin
        if (sum_q < 0) y_q <= '0;
        else if (sum_q > $signed({2'b00, Q30_ONE})) y_q <= Q30_ONE;
        else y_q <= 31'(sum_q);
      end
      OP_SQR: y_q <= 31'(ysq >> 30);
      OP_EFIN: e_q <= (func_q == FUNC_MEAS && !sts_o.s_big)
                    ? 17'((32'(y_q) + 32'd8192) >> 14) : '0;
      OP_ERRX: ex_q <= err_val;
      OP_ERRY: ey_q <= err_val;
      OP_SRCH: begin
        if (match) begin
          hit_ex_q <= $signed(rd_q[2*ERR_W-1 -: ERR_W]);
          hit_ey_q <= $signed(rd_q[ERR_W-1:0]);
        end
      end
      OP_INSERT: begin
        if (ins_ok) begin
          hit_ex_q <= ex_q;
          hit_ey_q <= ey_q;
        end
      end
      OP_OUT: begin
        found_q <= hit_q;
        app_x_q <= sel_ex;
        app_y_q <= sel_ey;
        if (func_q == FUNC_MEAS) begin
          cor_x_q <= sat_x;
          cor_y_q <= sat_y;
          cor_z_q <= pz_q;
        end else begin
          cor_x_q <= '0;
          cor_y_q <= '0;
          cor_z_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.func      = func_q;
  assign sts_o.s_big     = (s_q >= 49'({scale_eff, 4'd0}));
  assign sts_o.div_done  = (dcnt_q == '0);
  assign sts_o.srch_done = match || (!pend_q && (sidx_q >= fill_q));
  assign sts_o.on_grid   = on_grid_q;

  assign out_corrected_x_o   = cor_x_q;
  assign out_corrected_y_o   = cor_y_q;
  assign out_corrected_z_o   = cor_z_q;
  assign out_applied_err_x_o = app_x_q;
  assign out_applied_err_y_o = app_y_q;
  assign out_key_found_o     = found_q;

endmodule

// File: sv/position_error_fingerprint_corrector.sv
// Top level of the position error fingerprint corrector.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | in_valid_i / in_stall_o    | func, source, pos_x, pos_y, pos_z
//  output   | out_valid_o / out_stall_i  | corrected x/y/z, applied_err x/y, key_found
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One request at a time. A reference update only loads the reference register; a
// query forms the cell key and, for a point on the grid, searches the table; a
// measurement does the exponent work (20-step ratio division, then 13 series
// terms each a multiply and a 31-step divide, four squarings) plus the linear
// table search, 1 entry a cycle, up to the fill count. The table needs no
// clearing pass: the fill count marks the live entries. A finished result waits
// in the output register while the next request is taken; a stalled result holds until taken.
`timescale 1ns / 1ps

module position_error_fingerprint_corrector
  import pefc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              in_func_i,
  input  logic [1:0]              in_source_i,
  input  logic signed [POS_W-1:0] in_pos_x_i,
  input  logic signed [POS_W-1:0] in_pos_y_i,
  input  logic signed [POS_W-1:0] in_pos_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] out_corrected_x_o,
  output logic signed [OUT_W-1:0] out_corrected_y_o,
  output logic signed [POS_W-1:0] out_corrected_z_o,
  output logic signed [ERR_W-1:0] out_applied_err_x_o,
  output logic signed [ERR_W-1:0] out_applied_err_y_o,
  output logic                    out_key_found_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [3:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t sts;

  // Configuration writes are always taken; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground <= 2'd1;
      cfg_q.tol    <= '0;
      cfg_q.scale  <= 32'd3000000000;
      cfg_q.fp_en  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GROUND: cfg_q.ground <= cfg_data_i[1:0];
        REG_TOL:    cfg_q.tol    <= cfg_data_i[23:0];
        REG_SCALE:  cfg_q.scale  <= cfg_data_i;
        REG_FP_EN:  cfg_q.fp_en  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pefc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pefc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_i               (cfg_q),
    .sts_o               (sts),
    .in_func_i           (in_func_i),
    .in_source_i         (in_source_i),
    .in_pos_x_i          (in_pos_x_i),
    .in_pos_y_i          (in_pos_y_i),
    .in_pos_z_i          (in_pos_z_i),
    .out_corrected_x_o   (out_corrected_x_o),
    .out_corrected_y_o   (out_corrected_y_o),
    .out_corrected_z_o   (out_corrected_z_o),
    .out_applied_err_x_o (out_applied_err_x_o),
    .out_applied_err_y_o (out_applied_err_y_o),
    .out_key_found_o     (out_key_found_o)
  );

endmodule

// File: test/tb_position_error_fingerprint_corrector.sv
// Self-checking testbench for the position error fingerprint corrector.
`timescale 1ns / 1ps

module tb_position_error_fingerprint_corrector;
  import pefc_pkg::*;

  localparam int     CLK_HALF    = 4;
  localparam longint CYCLE_LIMIT = 6000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              in_func_i = '0;
  logic [1:0]              in_source_i = '0;
  logic signed [POS_W-1:0] in_pos_x_i = '0;
  logic signed [POS_W-1:0] in_pos_y_i = '0;
  logic signed [POS_W-1:0] in_pos_z_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] out_corrected_x_o;
  logic signed [OUT_W-1:0] out_corrected_y_o;
  logic signed [POS_W-1:0] out_corrected_z_o;
  logic signed [ERR_W-1:0] out_applied_err_x_o;
  logic signed [ERR_W-1:0] out_applied_err_y_o;
  logic                    out_key_found_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [3:0]              cfg_index_i = '0;
  logic [31:0]             cfg_data_i = '0;

  position_error_fingerprint_corrector DUT (.*);

  always #CLK_HALF clk_i = ~clk_i;

  // One corrected position as it leaves the block.
  typedef struct packed {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic signed [ERR_W-1:0] ex;
    logic signed [ERR_W-1:0] ey;
    logic                    found;
  } fix_t;

  fix_t fix_queue[$];

  // Mirror of the block state.
  cfg_t          cfg_m;
  longint        ref_xm[3];
  longint        ref_ym[3];
  longint        cell_xm[TABLE_DEPTH];
  longint        cell_ym[TABLE_DEPTH];
  longint        err_xm[TABLE_DEPTH];
  longint        err_ym[TABLE_DEPTH];
  int            fill_m;

  int     send_idle_pct;
  int     stall_pct;
  int     mismatches;
  longint cycles;

  // Cell index: divide toward zero.
  function automatic longint cell_of(longint p);
    cell_of = p / CELL_MM;
  endfunction

  function automatic int lookup_cell(longint cx, longint cy);
    lookup_cell = -1;
    for (int i = 0; i < fill_m; i++)
      if (cell_xm[i] == cx && cell_ym[i] == cy) return i;
  endfunction

  // exp(-t), t in Q16, result in Q16, by series on t/16 then four squarings.
  function automatic longint gauss_q16(longint t);
    longint u, term, sum;
    longint unsigned y;
    u = t << 10;
    term = longint'(1) << 30;
    sum = term;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = ((term * u) >>> 30) / k;
      if (k % 2) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    y = sum;
    for (int i = 0; i < SQR_ROUNDS; i++) y = (y * y + (64'd1 << 29)) >> 30;
    gauss_q16 = (y + (64'd1 << 13)) >> 14;
  endfunction

  function automatic longint axis_err(longint d, longint e);
    longint mag, ad;
    ad = d < 0 ? -d : d;
    if (ad <= longint'(cfg_m.tol)) return 0;
    mag = (ad * e + 32768) >>> 16;
    axis_err = d < 0 ? -mag : mag;
  endfunction

  function automatic longint clip25(longint v);
    clip25 = v > 16777215 ? 16777215 : (v < -16777216 ? -16777216 : v);
  endfunction

  // Update the mirror for one request; push the expected fix if any.
  task automatic predict_fix(logic [1:0] fn, logic [1:0] src, longint px, longint py,
                             longint pz);
    longint gx, gy, dx, dy, ex, ey, e, ax, ay, cx, cy;
    longint unsigned s, sc;
    int idx;
    fix_t f;
    gx = 0; gy = 0; e = 0; ax = 0; ay = 0; idx = -1;
    cx = cell_of(px);
    cy = cell_of(py);
    f = '0;
    if (fn == FUNC_REF) begin
      if (src != 2'd3) begin
        ref_xm[src] = px;
        ref_ym[src] = py;
      end
    end else if (fn == FUNC_MEAS) begin
      if (cfg_m.ground != GROUND_NONE) begin
        gx = ref_xm[cfg_m.ground];
        gy = ref_ym[cfg_m.ground];
      end
      dx = gx - px;
      dy = gy - py;
      s = dx * dx + dy * dy;
      sc = cfg_m.scale == 0 ? 64'd1 : 64'(cfg_m.scale);
      if (s < 16 * sc) e = gauss_q16((s << 16) / sc);
      ex = axis_err(dx, e);
      ey = axis_err(dy, e);
      if (cfg_m.fp_en && (ex != 0 || ey != 0) && lookup_cell(cx, cy) < 0
          && fill_m < TABLE_DEPTH) begin
        cell_xm[fill_m] = cx;
        cell_ym[fill_m] = cy;
        err_xm[fill_m] = ex;
        err_ym[fill_m] = ey;
        fill_m++;
      end
      idx = lookup_cell(cx, cy);
      if (idx >= 0) begin
        ax = err_xm[idx];
        ay = err_ym[idx];
      end
      f.cx = OUT_W'(clip25(px + ax));
      f.cy = OUT_W'(clip25(py + ay));
      f.cz = POS_W'(pz);
    end else if (fn == FUNC_QUERY) begin
      if (px % CELL_MM == 0 && py % CELL_MM == 0) idx = lookup_cell(cx, cy);
      if (idx >= 0) begin
        ax = err_xm[idx];
        ay = err_ym[idx];
      end
    end
    if (fn == FUNC_MEAS || fn == FUNC_QUERY) begin
      f.ex = ERR_W'(ax);
      f.ey = ERR_W'(ay);
      f.found = idx >= 0;
      fix_queue.push_back(f);
    end
  endtask

  // Send one request; hold it until accepted. Valid stays up for a request
  // that follows at once; an idle cycle or the drain drops it.
  task automatic send_request(logic [1:0] fn, logic [1:0] src, logic [23:0] px,
                              logic [23:0] py, logic [23:0] pz);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_func_i <= fn;
    in_source_i <= src;
    in_pos_x_i <= px;
    in_pos_y_i <= py;
    in_pos_z_i <= pz;
    predict_fix(fn, src, longint'($signed(px)), longint'($signed(py)),
                longint'($signed(pz)));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Write one register while the block is idle; the next request drops valid.
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GROUND: cfg_m.ground = val[1:0];
      REG_TOL:    cfg_m.tol = val[23:0];
      REG_SCALE:  cfg_m.scale = val;
      REG_FP_EN:  cfg_m.fp_en = val[0];
      default: ;
    endcase
  endtask

  // Wait out all expected fixes plus the longest measurement.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (fix_queue.size() != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  // Random coordinate: mostly near the origin, sometimes anywhere.
  function automatic logic [23:0] rand_pos();
    case ($urandom_range(3))
      0: rand_pos = 24'($urandom);
      1: rand_pos = 24'(int'($urandom_range(4000)) - 2000);
      2: rand_pos = 24'((int'($urandom_range(80)) - 40) * CELL_MM);
      default: rand_pos = 24'(int'($urandom_range(600000)) - 300000);
    endcase
  endfunction

  // Check each accepted fix against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        fix_t got, want;
        got = {out_corrected_x_o, out_corrected_y_o, out_corrected_z_o,
               out_applied_err_x_o, out_applied_err_y_o, out_key_found_o};
        if (fix_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = fix_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_position_error_fingerprint_corrector failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(FUNC_MEAS, 2'd0, 24'd150, 24'd250, 24'h7FFFFF);
    send_request(FUNC_REF, 2'd1, 24'd1000, -24'sd500, 24'd0);
    send_request(FUNC_REF, 2'd0, 24'h7FFFFF, 24'h800000, 24'd0);
    send_request(FUNC_REF, 2'd2, 24'h800000, 24'h7FFFFF, 24'd0);
    send_request(FUNC_REF, 2'd3, 24'd9, 24'd9, 24'd0);
    send_request(FUNC_MEAS, 2'd0, 24'd150, 24'd250, 24'h800000);
    send_request(FUNC_MEAS, 2'd0, -24'sd150, -24'sd250, 24'd1);
    send_request(FUNC_MEAS, 2'd0, 24'd199, -24'sd99, 24'd0);
    send_request(FUNC_QUERY, 2'd0, 24'd100, 24'd200, 24'd5);
    send_request(FUNC_QUERY, 2'd0, -24'sd100, -24'sd200, 24'd5);
    send_request(FUNC_QUERY, 2'd0, 24'd101, 24'd200, 24'd5);
    send_request(FUNC_QUERY, 2'd0, 24'd0, 24'd0, 24'd0);
    send_request(2'd3, 2'd2, 24'd100, 24'd200, 24'd7);
    send_request(FUNC_MEAS, 2'd1, 24'h800000, 24'h800000, 24'd3);
    send_request(FUNC_MEAS, 2'd1, 24'h7FFFFF, 24'h7FFFFF, 24'd3);
    drain();
    write_reg(REG_GROUND, 32'd0);
    write_reg(REG_SCALE, 32'd1);
    write_reg(4'd9, 32'hFFFFFFFF);
    send_request(FUNC_MEAS, 2'd0, 24'h800000, 24'h800000, 24'd0);
    send_request(FUNC_MEAS, 2'd0, 24'h7FFFFE, 24'h7FFFFF, 24'd0);
    drain();
    write_reg(REG_SCALE, 32'd0);
    write_reg(REG_GROUND, 32'd3);
    send_request(FUNC_MEAS, 2'd0, 24'd0, 24'd0, 24'd0);
    send_request(FUNC_MEAS, 2'd0, 24'd0, 24'd1, 24'd0);
    drain();
  endtask

  // Random requests under one register setting.
  task automatic test_random_phase(int n, logic [1:0] gnd, logic [23:0] tol,
                                   logic [31:0] sc, logic fp);
    logic [1:0] fn;
    write_reg(REG_GROUND, 32'(gnd));
    write_reg(REG_TOL, 32'(tol));
    write_reg(REG_SCALE, sc);
    write_reg(REG_FP_EN, 32'(fp));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: fn = FUNC_REF;
        2, 3: fn = FUNC_QUERY;
        4: fn = 2'($urandom_range(3));
        default: fn = FUNC_MEAS;
      endcase
      send_request(fn, 2'($urandom_range(3)), rand_pos(), rand_pos(), 24'($urandom));
    end
    drain();
  endtask

  // Store a run of distinct cells far from the reference, then look one up.
  task automatic test_table_fill();
    write_reg(REG_GROUND, 32'd2);
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_SCALE, 32'hFFFFFFFF);
    write_reg(REG_FP_EN, 32'd1);
    send_request(FUNC_REF, 2'd2, 24'd20000, 24'd20000, 24'd0);
    for (int i = 0; i < 20; i++)
      send_request(FUNC_MEAS, 2'd0, 24'((i % 5) * CELL_MM + 5),
                   24'((i / 5) * CELL_MM - 2000), 24'(i));
    send_request(FUNC_MEAS, 2'd0, -24'sd9000, -24'sd9000, 24'd0);
    send_request(FUNC_QUERY, 2'd0, 24'd0, -24'sd2000, 24'd0);
    drain();
  endtask

  initial begin
    cfg_m = '{ground: 2'd1, tol: 24'd0, scale: 32'd3000000000, fp_en: 1'b1};
    ref_xm = '{default: 0};
    ref_ym = '{default: 0};
    fill_m = 0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(120, 2'd1, 24'd0, 32'd3000000000, 1'b1);
    send_idle_pct = 74;
    test_random_phase(120, 2'd0, 24'd50, 32'd2000000, 1'b1);
    send_idle_pct = 0;
    stall_pct = 74;
    test_random_phase(120, 2'd2, 24'hFFFFFF, 32'd40000, 1'b0);
    send_idle_pct = 13;
    stall_pct = 13;
    test_random_phase(140, 2'd3, 24'd500, 32'hFFFFFFFF, 1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    test_table_fill();
    if (mismatches == 0 && fix_queue.size() == 0)
      $display("tb_position_error_fingerprint_corrector passed");
    else
      $display("tb_position_error_fingerprint_corrector failed");
    $finish;
  end

endmodule
